// File: rtl/rble_pkg.sv
// Shared types and constants for the ring buffer line extractor.
`default_nettype none
package rble_pkg;
	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned BYTE_W = 8;
	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'd0;
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef struct packed {
		logic mode;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] delimiter;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic byte_valid;
		logic line_found;
		logic last;
	} out_item_t;
endpackage
`default_nettype wire

// File: rtl/rble_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module rble_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/rble_store.sv
// Byte store: RAM plus per-entry written flags so unwritten slots read as zero.
`default_nettype none
module rble_store import rble_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [BYTE_W-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [BYTE_W-1:0] rdata
);
	logic [DEPTH-1:0] wr_q;
	logic rd_wr_q;
	logic [BYTE_W-1:0] ram_rdata;

	rble_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// mark written entries; sample the flag alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_wr_q <= 1'b0;
		end else begin
			if (we) begin
				wr_q[waddr] <= 1'b1;
			end
			rd_wr_q <= wr_q[raddr];
		end
	end

	assign rdata = rd_wr_q ? ram_rdata : ZERO_BYTE;
endmodule
`default_nettype wire

// File: rtl/ring_buffer_line_extractor_top.sv
// Top level: ring byte store with push and delimited line extraction.
// Push: taken in ST_IDLE, no result beat; a push may follow every cycle while no extract is under way.
// Extract: each scanned slot takes one store read (ST_RD), then one compare (ST_CMP); the run
//   closes in ST_FIN with the last beat, and no new item is taken until the sequencer is back
//   in ST_IDLE; result stalls hold ST_CMP and ST_FIN.
// Reset clears both positions and the written flags, so the whole store reads as zero.
`default_nettype none
module ring_buffer_line_extractor_top import rble_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire in_item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output out_item_t result
);
	localparam int unsigned PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic [PW-1:0] pos_q;
	logic [BYTE_W-1:0] dlm_q;
	logic pend_q;
	logic [BYTE_W-1:0] pend_byte_q;
	logic pend_bv_q;
	logic found_q;
	logic out_vld_q;
	out_item_t out_q;

	logic push_acc;
	logic ext_acc;
	logic out_free;
	logic emit;
	logic [BYTE_W-1:0] rdata;
	logic match;
	logic at_w;
	logic clr;
	logic st_we;
	logic [PW-1:0] st_waddr;
	logic [BYTE_W-1:0] st_wdata;
	logic [PW-1:0] pos_nx;
	logic [PW-1:0] wp_nx;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		ring_next = (p == LAST_POS) ? '0 : p + 1'b1;
	endfunction

	// hold off new items while a scan is under way
	assign item_stall = (state_q != ST_IDLE);
	assign push_acc = item_valid && !item_stall && (item.mode == MODE_PUSH);
	assign ext_acc = item_valid && !item_stall && (item.mode == MODE_EXTRACT);

	// output register may take a new beat when empty or being drained
	assign out_free = !out_vld_q || !result_stall;

	// a beat leaves when a pending byte is released or the run closes
	assign emit = ((state_q == ST_CMP) && !match && pend_q) || (state_q == ST_FIN);

	// the shared compare unit: stored byte against delimiter, position against write
	assign match = (rdata == dlm_q);
	assign at_w = (pos_q == wp_q);
	assign clr = (state_q == ST_CMP) && out_free && match;
	assign pos_nx = ring_next(pos_q);
	assign wp_nx = ring_next(wp_q);

	// one write port: push data, or zero over a matched delimiter
	assign st_we = push_acc || clr;
	assign st_waddr = push_acc ? wp_q : pos_q;
	assign st_wdata = push_acc ? item.data_byte : ZERO_BYTE;

	rble_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(pos_q),
		.rdata(rdata)
	);

	// Sequencer. A scanned byte is held back one step as pending, since only
	// the next compare tells whether it is the last beat of a found line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q <= '0;
			wp_q <= '0;
			pos_q <= '0;
			dlm_q <= '0;
			pend_q <= 1'b0;
			pend_byte_q <= '0;
			pend_bv_q <= 1'b0;
			found_q <= 1'b0;
			out_vld_q <= 1'b0;
			out_q <= '0;
		end else begin
			// load a beat when the output is free; otherwise hold it
			if (out_free) begin
				out_vld_q <= emit;
			end
			case (state_q)
				ST_IDLE: begin
					if (push_acc) begin
						wp_q <= wp_nx;
					end
					if (ext_acc) begin
						pos_q <= rp_q;
						dlm_q <= item.delimiter;
						pend_q <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// store read of pos_q is in flight
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (out_free) begin
						if (!match && !at_w) begin
							// advance: release the pending byte, hold this one
							if (pend_q) begin
								out_q <= '{pend_byte_q, 1'b1, 1'b0, 1'b0};
							end
							pend_q <= 1'b1;
							pend_byte_q <= rdata;
							pend_bv_q <= 1'b1;
							pos_q <= pos_nx;
							state_q <= ST_RD;
						end else if (match) begin
							// line found: consume the delimiter unless at write position
							rp_q <= at_w ? pos_q : pos_nx;
							found_q <= 1'b1;
							if (!pend_q) begin
								pend_q <= 1'b1;
								pend_byte_q <= ZERO_BYTE;
								pend_bv_q <= 1'b0;
							end
							state_q <= ST_FIN;
						end else begin
							// no delimiter before write position: append a newline
							if (pend_q) begin
								out_q <= '{pend_byte_q, 1'b1, 1'b0, 1'b0};
							end
							pend_q <= 1'b1;
							pend_byte_q <= NEWLINE_BYTE;
							pend_bv_q <= 1'b1;
							found_q <= 1'b0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_q <= '{pend_byte_q, pend_bv_q, found_q, 1'b1};
						pend_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_vld_q;
	assign result = out_q;

	// positions stay inside the ring for any depth
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= LAST_POS) && (wp_q <= LAST_POS) && (pos_q <= LAST_POS))
		else $error("ring position out of range");

	// a push moves the write position by exactly one slot
	a_push_adv: assert property (@(posedge clk) disable iff (!arst_n)
		push_acc |=> (wp_q == $past(wp_nx)))
		else $error("write position did not advance on push");

	// a delimiter matched at the write position consumes nothing past it
	a_stale_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(clr && at_w) |=> (rp_q == $past(pos_q)))
		else $error("read position moved past write position");

	// the closing step always issues a last-marked beat
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && out_free) |=> (result_valid && result.last))
		else $error("extract run ended without a last beat");

	// a beat without a byte is only the empty found line
	a_empty_line: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.byte_valid) |-> (result.line_found && result.last))
		else $error("byte-less beat that is not an empty found line");
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the ring buffer line extractor: random push and extract beats.
`timescale 1ns / 100ps
module tb_top;
	import rble_pkg::*;

	// Track the byte ring as the block should hold it and queue the result beats it owes.
	class line_tracker;
		logic [BYTE_W-1:0] ring_copy [DEPTH_DEF];
		int unsigned rd_pos;
		int unsigned wr_pos;
		int unsigned faults;
		out_item_t beats_due [$];

		function new();
			foreach (ring_copy[i])
				ring_copy[i] = ZERO_BYTE;
			rd_pos = 0;
			wr_pos = 0;
			faults = 0;
		endfunction

		// Bytes between the read and the write position.
		function int unsigned backlog();
			return (wr_pos + DEPTH_DEF - rd_pos) % DEPTH_DEF;
		endfunction

		// Apply one accepted input beat and queue the result beats it causes.
		function void note_item(in_item_t it);
			out_item_t beat;
			int unsigned scan;
			int unsigned count;
			if (it.mode == MODE_PUSH) begin
				ring_copy[wr_pos] = it.data_byte;
				wr_pos = (wr_pos + 1) % DEPTH_DEF;
				return;
			end
			scan = rd_pos;
			count = 0;
			while (ring_copy[scan] != it.delimiter && scan != wr_pos && count < DEPTH_DEF) begin
				beat = '{out_byte: ring_copy[scan], byte_valid: 1'b1, line_found: 1'b0,
					last: 1'b0};
				beats_due.insert(beats_due.size(), beat);
				count++;
				scan = (scan + 1) % DEPTH_DEF;
			end
			// The stop slot is compared even when it sits at the write position.
			if (ring_copy[scan] == it.delimiter) begin
				ring_copy[scan] = ZERO_BYTE;
				rd_pos = (scan != wr_pos) ? (scan + 1) % DEPTH_DEF : scan;
				if (count == 0) begin
					beat = '{out_byte: ZERO_BYTE, byte_valid: 1'b0, line_found: 1'b1,
						last: 1'b1};
				end else begin
					beat = beats_due.pop_back();
					beat.line_found = 1'b1;
					beat.last = 1'b1;
				end
			end else begin
				beat = '{out_byte: NEWLINE_BYTE, byte_valid: 1'b1, line_found: 1'b0,
					last: 1'b1};
			end
			beats_due.insert(beats_due.size(), beat);
		endfunction

		// Compare one accepted result beat with the oldest one owed.
		function void check_beat(out_item_t got);
			out_item_t want;
			if (beats_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result beat: byte %02h valid %b found %b last %b",
						got.out_byte, got.byte_valid, got.line_found, got.last);
				return;
			end
			want = beats_due.pop_front();
			if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.line_found !== want.line_found || got.last !== want.last) begin
				faults++;
				if (faults <= 10)
					$display({"result mismatch: expected byte %02h valid %b found %b last %b,",
						" got byte %02h valid %b found %b last %b"},
						want.out_byte, want.byte_valid, want.line_found, want.last,
						got.out_byte, got.byte_valid, got.line_found, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;

	line_tracker tracker;
	int unsigned items_sent = 0;
	// When set, the side concerned neither idles nor stalls.
	bit send_calm = 1'b0;
	bit sink_calm = 1'b0;

	ring_buffer_line_extractor_top #(.DEPTH(DEPTH_DEF)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #2 clk = ~clk;

	// Offer one input beat after a random gap and hold it until the block takes it.
	// Handshake signals are sampled at the falling edge, where nothing moves.
	task automatic send_item(in_item_t it);
		int unsigned gap;
		logic free;
		gap = send_calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			free = (item_stall === 1'b0);
			@(posedge clk);
		end while (!free);
		tracker.note_item(it);
		items_sent++;
	endtask

	// Push one byte; the delimiter field is ignored here, so fill it with noise.
	task automatic push_byte(logic [BYTE_W-1:0] b);
		in_item_t it;
		it.mode = MODE_PUSH;
		it.data_byte = b;
		it.delimiter = BYTE_W'($urandom_range(0, 255));
		send_item(it);
	endtask

	// Extract one line; the data field is ignored, so fill it with noise.
	task automatic extract_line(logic [BYTE_W-1:0] dlm);
		in_item_t it;
		it.mode = MODE_EXTRACT;
		it.data_byte = BYTE_W'($urandom_range(0, 255));
		it.delimiter = dlm;
		send_item(it);
	endtask

	// Drop valid and hold off until every owed result beat has arrived.
	task automatic hold_until_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.beats_due.size() != 0);
	endtask

	// Favour a few common delimiters so that lines are actually found.
	function automatic logic [BYTE_W-1:0] pick_delim();
		case ($urandom_range(0, 3))
			0: return NEWLINE_BYTE;
			1: return ZERO_BYTE;
			2: return 8'h3b;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Result side: stall for a random spell before each beat, then take it.
	initial begin
		int unsigned hold;
		logic took;
		out_item_t seen;
		wait (arst_n === 1'b1);
		forever begin
			hold = sink_calm ? 0 : $urandom_range(0, 7);
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do begin
				@(negedge clk);
				took = (result_valid === 1'b1);
				seen = result;
				@(posedge clk);
			end while (!took);
			tracker.check_beat(seen);
		end
	end

	// Stimulus and verdict.
	initial begin
		int unsigned pick;
		int unsigned len;
		int unsigned fill;
		int unsigned rand_goal;
		bit full_done;
		logic [BYTE_W-1:0] dlm;
		logic [BYTE_W-1:0] b;
		tracker = new();
		full_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Empty store: the write slot still reads zero, so a zero delimiter
		// matches there and gives an empty found line; any other gives a lone newline.
		extract_line(ZERO_BYTE);
		extract_line(8'hff);
		// Plain line with the top byte as delimiter.
		push_byte(8'h41);
		push_byte(8'h42);
		push_byte(8'hff);
		extract_line(8'hff);
		// Delimiter right at the read position: empty found line.
		push_byte(ZERO_BYTE);
		extract_line(ZERO_BYTE);
		// No delimiter before the write position: bytes then a newline, read kept.
		push_byte(8'h5a);
		push_byte(8'h33);
		extract_line(8'h77);
		// Stale compare: the unwritten slot at the write position reads zero and matches it.
		extract_line(ZERO_BYTE);
		// Read equals write, slot still zero: empty found line once more.
		extract_line(ZERO_BYTE);
		// Sign-bit extremes in the data, delimiter with only the low bit set.
		push_byte(8'h80);
		push_byte(8'h7f);
		push_byte(8'h01);
		push_byte(8'hfe);
		extract_line(8'h01);
		extract_line(NEWLINE_BYTE);
		extract_line(8'hfe);

		// Let the block run dry once before the random part.
		hold_until_drained();

		rand_goal = items_sent + 170;
		while (items_sent < rand_goal) begin
			// Switch idling on and off for each side now and then.
			if ($urandom_range(0, 15) == 0)
				send_calm = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 15) == 0)
				sink_calm = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				// Well-formed line: random bytes, the delimiter, then extract it.
				dlm = pick_delim();
				len = $urandom_range(0, 8);
				repeat (len) push_byte(BYTE_W'($urandom_range(0, 255)));
				push_byte(dlm);
				extract_line(dlm);
			end else if (pick < 74) begin
				extract_line(pick_delim());
			end else if (pick < 84) begin
				repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 87) begin
				// Overrun: wrap the write position past unread data.
				repeat ($urandom_range(20, 70)) push_byte(BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				hold_until_drained();
			end else begin
				// Broken line: extract with a delimiter other than the one pushed.
				dlm = pick_delim();
				push_byte(BYTE_W'($urandom_range(0, 255)));
				push_byte(dlm);
				extract_line(dlm ^ 8'h20);
			end

			// Once, fill the ring to one short of full and scan the lot.
			if (!full_done && items_sent + 90 >= rand_goal) begin
				full_done = 1'b1;
				dlm = pick_delim();
				fill = DEPTH_DEF - 1 - tracker.backlog();
				repeat (fill) begin
					b = BYTE_W'($urandom_range(0, 255));
					if (b == dlm)
						b = ~b;
					push_byte(b);
				end
				extract_line(dlm);
			end
		end

		item_valid <= 1'b0;
		while (tracker.beats_due.size() != 0)
			@(posedge clk);
		// Leave room for a stray beat after the last one owed.
		repeat (200) @(posedge clk);
		if (tracker.faults == 0 && tracker.beats_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: fail the run if it has not finished in time.
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// File: filelist.f
rtl/rble_pkg.sv
rtl/rble_ram.sv
rtl/rble_store.sv
rtl/ring_buffer_line_extractor_top.sv
bench/tb_top.sv
